### src/brtr_pkg.sv
// ----------------------------------------------------------------------------
// brtr_pkg
// Types, codes and the reply table contents of the remote-terminal responder.
// ----------------------------------------------------------------------------
package brtr_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	// sync field codes
	localparam logic [2:0] SYNC_DATA = 3'd1;
	localparam logic [2:0] SYNC_CMD  = 3'd4;
	localparam logic [2:0] SYNC_NONE = 3'd0;

	// mode-code subaddresses
	localparam logic [4:0] MODE_SA_LOW  = 5'd0;
	localparam logic [4:0] MODE_SA_HIGH = 5'd31;

	// result kinds
	localparam logic [2:0] KIND_STATUS  = 3'd0;
	localparam logic [2:0] KIND_DATA_TX = 3'd1;
	localparam logic [2:0] KIND_DATA_RX = 3'd2;
	localparam logic [2:0] KIND_CMD_EVT = 3'd3;
	localparam logic [2:0] KIND_INVALID = 3'd4;

	// spacecraft command codes
	localparam logic [2:0] CODE_PICTURE   = 3'd0;
	localparam logic [2:0] CODE_THRUSTER  = 3'd1;
	localparam logic [2:0] CODE_WHEEL     = 3'd2;
	localparam logic [2:0] CODE_TELEMETRY = 3'd3;
	localparam logic [2:0] CODE_TRANSMIT  = 3'd4;
	localparam logic [2:0] CODE_NONE      = 3'd0;

	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_B     = 8'h42;
	localparam logic [7:0] CHAR_C     = 8'h43;
	localparam logic [7:0] CHAR_D     = 8'h44;

	typedef struct packed {
		logic [2:0]  word_sync;
		logic [15:0] word_body;
	} in_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [2:0]  out_sync;
		logic [15:0] out_body;
		logic        out_parity;
		logic [2:0]  command_code;
		logic        last;
	} out_t;

	// letter pairs, first character in the high byte; "AG" is skipped
	function automatic logic [15:0] table_entry(input logic [7:0] idx);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = 8'h00;
		lo = 8'h00;
		if (idx < 8'd6) begin
			hi = CHAR_A;
			lo = CHAR_A + idx;
		end else if (idx < 8'd25) begin
			hi = CHAR_A;
			lo = CHAR_A + idx + 8'd1;
		end else if (idx < 8'd51) begin
			hi = CHAR_B;
			lo = CHAR_A + (idx - 8'd25);
		end else if (idx < 8'd64) begin
			hi = CHAR_C;
			lo = CHAR_A + (idx - 8'd51);
		end
		return {hi, lo};
	endfunction

	function automatic logic [2:0] command_of(input logic [7:0] ch);
		logic [2:0] code;
		case (ch)
			CHAR_A:  code = CODE_PICTURE;
			CHAR_B:  code = CODE_THRUSTER;
			CHAR_C:  code = CODE_WHEEL;
			CHAR_D:  code = CODE_TELEMETRY;
			default: code = CODE_TRANSMIT;
		endcase
		return code;
	endfunction

endpackage

### src/brtr_table.sv
// ----------------------------------------------------------------------------
// brtr_table
// Reply table with one registered read port.
// ----------------------------------------------------------------------------
module brtr_table import brtr_pkg::*; #(
	parameter int TableDepth = TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TableDepth)
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= table_entry(8'(rd_addr));
	end

	assign rd_data = data_q;

endmodule

### src/brtr_seq.sv
// ----------------------------------------------------------------------------
// brtr_seq
// Word decoder, reply sequencer and output register of the responder.
// ----------------------------------------------------------------------------
module brtr_seq import brtr_pkg::*; #(
	parameter int TableDepth = TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TableDepth)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [4:0]    own_address,
	input  logic          word_valid,
	output logic          word_stall,
	input  in_t           word,
	output logic          result_valid,
	input  logic          result_stall,
	output out_t          result,
	output logic          busy,
	output logic [AW-1:0] rd_addr,
	input  logic [15:0]   rd_data
);

	logic          busy_q;
	logic          arm_q;
	logic [4:0]    cnt_q;
	logic [AW-1:0] idx_q;
	logic          res_valid_q;
	out_t          res_q;

	logic          load_ok;
	logic          accept;
	logic          step;
	logic [AW-1:0] idx_next;

	logic [4:0]    w_addr;
	logic          w_tr;
	logic [4:0]    w_sa;
	logic [4:0]    w_cnt;
	logic [7:0]    w_c1;
	logic [7:0]    w_c2;
	logic [15:0]   status_body;

	logic          dec_emit;
	logic          dec_stream;
	logic          dec_set_arm;
	logic          dec_clr_arm;
	out_t          dec_res;
	out_t          data_res;

	assign w_addr = word.word_body[15:11];
	assign w_tr   = word.word_body[10];
	assign w_sa   = word.word_body[9:5];
	assign w_cnt  = word.word_body[4:0];
	assign w_c1   = word.word_body[15:8];
	assign w_c2   = word.word_body[7:0];

	assign status_body = {own_address, 10'b0, 1'b1};

	// the output register frees up when empty or when its beat is taken
	assign load_ok    = !res_valid_q || !result_stall;
	assign word_stall = busy_q || !load_ok;
	assign accept     = word_valid && !word_stall;
	assign step       = busy_q && load_ok;

	assign idx_next = (idx_q == AW'(TableDepth - 1)) ? '0 : idx_q + 1'b1;

	// look ahead so that rd_data always holds the entry at idx_q
	assign rd_addr = accept ? AW'(w_sa) : (step ? idx_next : idx_q);

	always_comb begin
		dec_emit    = 1'b0;
		dec_stream  = 1'b0;
		dec_set_arm = 1'b0;
		dec_clr_arm = 1'b0;
		dec_res     = '0;
		dec_res.last = 1'b1;
		if (word.word_sync == SYNC_CMD) begin
			if (w_addr == own_address) begin
				dec_res.result_kind = KIND_STATUS;
				dec_res.out_sync    = SYNC_CMD;
				dec_res.out_body    = status_body;
				dec_res.out_parity  = ~^{SYNC_CMD, status_body};
				if (w_sa == MODE_SA_LOW || w_sa == MODE_SA_HIGH) begin
					dec_emit    = 1'b1;
					dec_set_arm = (w_sa == MODE_SA_LOW);
				end else if (w_tr) begin
					dec_emit     = 1'b1;
					dec_stream   = (w_cnt != 5'd0);
					dec_res.last = (w_cnt == 5'd0);
				end
			end
		end else if (word.word_sync == SYNC_DATA) begin
			if (w_c1 == CHAR_SLASH) begin
				if (arm_q) begin
					dec_emit             = 1'b1;
					dec_clr_arm          = 1'b1;
					dec_res.result_kind  = KIND_CMD_EVT;
					dec_res.command_code = command_of(w_c2);
				end
			end else begin
				dec_emit            = 1'b1;
				dec_res.result_kind = KIND_DATA_RX;
				dec_res.out_body    = word.word_body;
			end
		end else begin
			dec_emit            = 1'b1;
			dec_res.result_kind = KIND_INVALID;
		end
	end

	always_comb begin
		data_res              = '0;
		data_res.result_kind  = KIND_DATA_TX;
		data_res.out_sync     = SYNC_DATA;
		data_res.out_body     = rd_data;
		data_res.out_parity   = ~^{SYNC_DATA, rd_data};
		data_res.command_code = CODE_NONE;
		data_res.last         = (cnt_q == 5'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			arm_q       <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			idx_q <= rd_addr;
			if (accept && dec_set_arm) begin
				arm_q <= 1'b1;
			end else if (accept && dec_clr_arm) begin
				arm_q <= 1'b0;
			end
			if (accept && dec_stream) begin
				busy_q <= 1'b1;
				cnt_q  <= w_cnt;
			end else if (step) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
				end
			end
			if ((accept && dec_emit) || step) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// hold the beat while stalled
	always_ff @(posedge clk) begin
		if (accept && dec_emit) begin
			res_q <= dec_res;
		end else if (step) begin
			res_q <= data_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign busy         = busy_q;

endmodule

### src/bus_remote_terminal_responder_top.sv
// ----------------------------------------------------------------------------
// bus_remote_terminal_responder_top
// Remote-terminal responder: decodes received bus words and emits replies.
// ----------------------------------------------------------------------------
// Usage:
//   word channel (word_valid / word_stall / word) carries one received word
//   per beat. result channel (result_valid / result_stall / result) carries
//   the replies and events, one per beat, last marking the final beat that
//   a word causes. cfg channel (cfg_valid / cfg_ready / cfg_data) writes the
//   terminal address; write it only while no reply is outstanding.
//   A result appears in the cycle after its word is taken; the next word
//   may follow unless the result side stalls. A transmit command with n
//   data words streams them after its status reply, one result per cycle
//   while result_stall is low, from the single read port of the reply table.
//   The word channel is stalled while those data words stream out.
//   Reset clears the armed command flag and sets the address to 1; the
//   reply table is constant and needs no clearing pass.
//   When result_stall is high the current beat is held and, once the
//   output register is occupied, word_stall rises as well.
// ----------------------------------------------------------------------------
module bus_remote_terminal_responder_top import brtr_pkg::*; #(
	parameter int TableDepth = TABLE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       word_valid,
	output logic       word_stall,
	input  in_t        word,
	output logic       result_valid,
	input  logic       result_stall,
	output out_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data
);

	localparam int AW = $clog2(TableDepth);

	logic [4:0]    own_address_q;
	logic          busy;
	logic [AW-1:0] rd_addr;
	logic [15:0]   rd_data;

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			own_address_q <= cfg_data;
		end
	end

	brtr_table #(
		.TableDepth(TableDepth)
	) u_table (
		.clk    (clk),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	brtr_seq #(
		.TableDepth(TableDepth)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_address (own_address_q),
		.word_valid  (word_valid),
		.word_stall  (word_stall),
		.word        (word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.busy        (busy),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

endmodule

### src/brtr_checker.sv
// ----------------------------------------------------------------------------
// brtr_checker
// Port-level checks of the responder, bound to the top level.
// ----------------------------------------------------------------------------
module brtr_checker import brtr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       word_valid,
	input logic       word_stall,
	input logic       result_valid,
	input logic       result_stall,
	input out_t       result
);

	// a stalled beat stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// every transmitted word carries odd parity
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == KIND_STATUS ||
		result.result_kind == KIND_DATA_TX) |->
		(^{result.out_sync, result.out_body, result.out_parity}) == 1'b1)
		else $error("transmitted word has even parity");

	// status beats carry the command sync and the terminal flag
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == KIND_STATUS |->
		result.out_sync == SYNC_CMD && result.out_body[0] && result.out_body[10:1] == '0)
		else $error("malformed status word");

	// an invalid word yields a single bare beat
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == KIND_INVALID |->
		result.last && result.out_body == '0 && result.out_sync == SYNC_NONE)
		else $error("invalid-word beat malformed");

	// hold the word channel until the final data beat of a reply is out
	a_data_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.result_kind == KIND_DATA_TX &&
		!result.last |-> !(word_valid && !word_stall))
		else $error("word taken while data words stream out");

endmodule

bind bus_remote_terminal_responder_top brtr_checker u_brtr_checker (.*);

### verif/tb_bus_remote_terminal_responder_top.sv
// ----------------------------------------------------------------------------
// tb_bus_remote_terminal_responder_top
// Self-checking bench for the remote-terminal responder.
// A directed table covers commands, mode codes, arming, command events,
// invalid syncs and address extremes. Random phases then run under several
// terminal addresses, the later ones with random gaps and stalls, and one long result hold.
// Every result beat is checked against a directed row or an in-bench model of the terminal.
// ----------------------------------------------------------------------------
module tb_bus_remote_terminal_responder_top import brtr_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROM_DEPTH      = 64;
	localparam int DRAIN_CYCLES   = 40;
	localparam int LONG_HOLD      = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 30;

	typedef struct {
		in_t  w;
		bit   typed;
		out_t r;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       word_valid = 1'b0;
	logic       word_stall;
	in_t        word = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	out_t       result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] cfg_data = '0;

	// model of the terminal
	logic [4:0]  rt_addr;
	bit          rt_armed;
	logic [15:0] reply_rom [ROM_DEPTH];

	out_t fresh_replies[$];
	out_t replies_due[$];
	row_t directed_rows[$];

	bit          quiet_bus = 1'b0;
	int unsigned holds_asked = 0;
	int unsigned holds_granted = 0;
	int unsigned fail_count = 0;
	int unsigned words_taken = 0;
	int unsigned answered_items = 0;
	int unsigned results_checked = 0;
	int unsigned events_seen = 0;
	int unsigned addresses_used = 0;
	int unsigned idle_cycles = 0;

	bus_remote_terminal_responder_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.word         (word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic out_t status_reply(input logic [4:0] addr);
		logic [15:0] body;
		body = {addr, 10'd0, 1'b1};
		return '{KIND_STATUS, SYNC_CMD, body, ~^{SYNC_CMD, body}, CODE_NONE, 1'b0};
	endfunction

	function automatic in_t make_cmd(input logic [4:0] addr, input logic tr,
			input logic [4:0] sa, input logic [4:0] cnt);
		return {SYNC_CMD, addr, tr, sa, cnt};
	endfunction

	function automatic in_t make_data(input logic [15:0] body);
		return {SYNC_DATA, body};
	endfunction

	// work out the beats one received word causes, and advance the model
	task automatic answer_word(input in_t w);
		logic [4:0] addr;
		logic [4:0] sa;
		logic [4:0] cnt;
		logic       tr;
		logic [2:0] code;
		logic [15:0] d;
		out_t       r;
		fresh_replies.delete();
		case (w.word_sync)
			SYNC_CMD: begin
				{addr, tr, sa, cnt} = w.word_body;
				if (addr == rt_addr) begin
					if (sa == MODE_SA_LOW || sa == MODE_SA_HIGH) begin
						fresh_replies.push_back(status_reply(rt_addr));
						if (sa == MODE_SA_LOW)
							rt_armed = 1'b1;
					end else if (tr) begin
						fresh_replies.push_back(status_reply(rt_addr));
						for (int i = 0; i < cnt; i++) begin
							d = reply_rom[(sa + i) % ROM_DEPTH];
							fresh_replies.push_back('{KIND_DATA_TX, SYNC_DATA, d,
								~^{SYNC_DATA, d}, CODE_NONE, 1'b0});
						end
					end
				end
			end
			SYNC_DATA: begin
				if (w.word_body[15:8] == CHAR_SLASH) begin
					if (rt_armed) begin
						case (w.word_body[7:0])
							CHAR_A:  code = CODE_PICTURE;
							CHAR_B:  code = CODE_THRUSTER;
							CHAR_C:  code = CODE_WHEEL;
							CHAR_D:  code = CODE_TELEMETRY;
							default: code = CODE_TRANSMIT;
						endcase
						fresh_replies.push_back('{KIND_CMD_EVT, SYNC_NONE, 16'h0000, 1'b0,
							code, 1'b0});
						rt_armed = 1'b0;
					end
				end else begin
					fresh_replies.push_back('{KIND_DATA_RX, SYNC_NONE, w.word_body, 1'b0,
						CODE_NONE, 1'b0});
				end
			end
			default: begin
				fresh_replies.push_back('{KIND_INVALID, SYNC_NONE, 16'h0000, 1'b0,
					CODE_NONE, 1'b0});
			end
		endcase
		if (fresh_replies.size() > 0) begin
			r = fresh_replies.pop_back();
			r.last = 1'b1;
			fresh_replies.push_back(r);
		end
	endtask

	task automatic note_mismatch(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got,
				want);
	endtask

	// offer one word, hold it while stalled, then book its replies
	task automatic offer_word(input in_t w, input bit typed, input out_t fixed);
		int gap;
		gap = (!quiet_bus && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			word_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		word = w;
		word_valid = 1'b1;
		do @(posedge clk); while (word_stall);
		words_taken++;
		answer_word(w);
		if (fresh_replies.size() > 0)
			answered_items++;
		if (typed)
			replies_due.push_back(fixed);
		else
			foreach (fresh_replies[i]) replies_due.push_back(fresh_replies[i]);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		word_valid = 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_address(input logic [4:0] a);
		@(negedge clk);
		cfg_data = a;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		rt_addr = a;
		addresses_used++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic add_row(input in_t w, input bit typed, input out_t r);
		row_t row;
		row.w = w;
		row.typed = typed;
		row.r = r;
		directed_rows.push_back(row);
	endtask

	task automatic load_directed();
		out_t st1;
		out_t none;
		st1 = '{KIND_STATUS, SYNC_CMD, 16'h0801, 1'b0, CODE_NONE, 1'b1};
		none = '0;
		add_row(make_cmd(5'd1, 1'b1, MODE_SA_LOW, 5'd0), 1'b1, st1);
		add_row(make_data({CHAR_SLASH, CHAR_A}), 1'b1,
			'{KIND_CMD_EVT, SYNC_NONE, 16'h0000, 1'b0, CODE_PICTURE, 1'b1});
		// marker with the flag already spent
		add_row(make_data({CHAR_SLASH, CHAR_B}), 1'b0, none);
		add_row(make_cmd(5'd1, 1'b0, MODE_SA_HIGH, 5'd0), 1'b1, st1);
		add_row(make_data({CHAR_SLASH, CHAR_C}), 1'b0, none);
		add_row(make_cmd(5'd1, 1'b0, MODE_SA_LOW, 5'd17), 1'b1, st1);
		add_row(make_data({CHAR_SLASH, CHAR_C}), 1'b1,
			'{KIND_CMD_EVT, SYNC_NONE, 16'h0000, 1'b0, CODE_WHEEL, 1'b1});
		add_row(make_cmd(5'd1, 1'b1, MODE_SA_LOW, 5'd31), 1'b1, st1);
		add_row(make_data({CHAR_SLASH, CHAR_D}), 1'b1,
			'{KIND_CMD_EVT, SYNC_NONE, 16'h0000, 1'b0, CODE_TELEMETRY, 1'b1});
		add_row(make_cmd(5'd1, 1'b0, MODE_SA_LOW, 5'd0), 1'b1, st1);
		add_row(make_data({CHAR_SLASH, 8'h5A}), 1'b1,
			'{KIND_CMD_EVT, SYNC_NONE, 16'h0000, 1'b0, CODE_TRANSMIT, 1'b1});
		add_row(make_cmd(5'd1, 1'b1, MODE_SA_LOW, 5'd5), 1'b1, st1);
		add_row(make_data({CHAR_SLASH, 8'hFF}), 1'b1,
			'{KIND_CMD_EVT, SYNC_NONE, 16'h0000, 1'b0, CODE_TRANSMIT, 1'b1});
		// foreign terminals: no reply, and no arming
		add_row(make_cmd(5'd31, 1'b1, MODE_SA_LOW, 5'd0), 1'b0, none);
		add_row(make_data({CHAR_SLASH, CHAR_A}), 1'b0, none);
		add_row(make_cmd(5'd0, 1'b1, 5'd3, 5'd4), 1'b0, none);
		add_row(make_data(16'hFFFF), 1'b1,
			'{KIND_DATA_RX, SYNC_NONE, 16'hFFFF, 1'b0, CODE_NONE, 1'b1});
		add_row(make_data(16'h0000), 1'b1,
			'{KIND_DATA_RX, SYNC_NONE, 16'h0000, 1'b0, CODE_NONE, 1'b1});
		add_row({SYNC_NONE, 16'hFFFF}, 1'b1,
			'{KIND_INVALID, SYNC_NONE, 16'h0000, 1'b0, CODE_NONE, 1'b1});
		add_row({3'd7, 16'h0000}, 1'b1,
			'{KIND_INVALID, SYNC_NONE, 16'h0000, 1'b0, CODE_NONE, 1'b1});
		add_row(make_cmd(5'd1, 1'b1, 5'd1, 5'd0), 1'b1, st1);
		add_row(make_cmd(5'd1, 1'b1, 5'd1, 5'd31), 1'b0, none);
		add_row(make_cmd(5'd1, 1'b1, 5'd30, 5'd31), 1'b0, none);
		add_row(make_cmd(5'd1, 1'b0, 5'd5, 5'd9), 1'b0, none);
		add_row(make_cmd(5'd1, 1'b1, MODE_SA_HIGH, 5'd31), 1'b1, st1);
	endtask

	task automatic random_traffic(input int unsigned target);
		int unsigned start;
		int          pick;
		logic [4:0]  addr;
		logic [4:0]  sa;
		logic [4:0]  cnt;
		logic [7:0]  ch;
		logic [2:0]  sync;
		start = words_taken;
		while (words_taken - start < target) begin
			pick = int'($urandom_range(0, 99));
			sa = 5'($urandom_range(1, 30));
			cnt = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(0, 4));
			if (pick < 45) begin
				case ($urandom_range(0, 9))
					0:       sa = MODE_SA_LOW;
					1:       sa = MODE_SA_HIGH;
					default: ;
				endcase
				offer_word(make_cmd(rt_addr, 1'($urandom_range(0, 1)), sa, cnt),
					1'b0, '0);
			end else if (pick < 55) begin
				addr = 5'($urandom);
				if (addr == rt_addr)
					addr = addr + 5'd1;
				offer_word({SYNC_CMD, addr, 11'($urandom)}, 1'b0, '0);
			end else if (pick < 65) begin
				// arm, then fire a command marker
				offer_word(make_cmd(rt_addr, 1'($urandom_range(0, 1)), MODE_SA_LOW, cnt),
					1'b0, '0);
				ch = ($urandom_range(0, 9) < 7) ? CHAR_A + 8'($urandom_range(0, 3))
					: 8'($urandom);
				offer_word(make_data({CHAR_SLASH, ch}), 1'b0, '0);
			end else if (pick < 85) begin
				offer_word(make_data(16'($urandom)), 1'b0, '0);
			end else if (pick < 93) begin
				offer_word(make_data({CHAR_SLASH, 8'($urandom)}), 1'b0, '0);
			end else begin
				do sync = 3'($urandom_range(0, 7));
				while (sync == SYNC_CMD || sync == SYNC_DATA);
				offer_word({sync, 16'($urandom)}, 1'b0, '0);
			end
		end
	endtask

	// result side: random stalls, plus a long hold when one is asked for
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_stall = 1'b1;
			end else if (holds_granted != holds_asked) begin
				holds_granted++;
				stall_left = LONG_HOLD - 1;
				result_stall = 1'b1;
			end else if (!quiet_bus && $urandom_range(0, 7) == 0) begin
				stall_left = pick_gap() - 1;
				result_stall = 1'b1;
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (result.result_kind == KIND_CMD_EVT)
				events_seen++;
			if (replies_due.size() == 0) begin
				note_mismatch("unexpected result beat", result, 0);
			end else begin
				want = replies_due.pop_front();
				if (result.result_kind !== want.result_kind)
					note_mismatch("result_kind", result.result_kind, want.result_kind);
				if (result.out_sync !== want.out_sync)
					note_mismatch("out_sync", result.out_sync, want.out_sync);
				if (result.out_body !== want.out_body)
					note_mismatch("out_body", result.out_body, want.out_body);
				if (result.out_parity !== want.out_parity)
					note_mismatch("out_parity", result.out_parity, want.out_parity);
				if (result.command_code !== want.command_code)
					note_mismatch("command_code", result.command_code, want.command_code);
				if (result.last !== want.last)
					note_mismatch("last", result.last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((word_valid && !word_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, replies_due.size());
			$display("FAIL bus_remote_terminal_responder_top");
			$finish;
		end
	end

	initial begin
		int n;
		n = 0;
		for (int hi = CHAR_A; hi <= CHAR_C; hi++)
			for (int lo = CHAR_A; lo <= CHAR_A + 25; lo++)
				if (n < ROM_DEPTH && !(hi == CHAR_A && lo == CHAR_A + 6)) begin
					reply_rom[n] = {8'(hi), 8'(lo)};
					n++;
				end
		rt_addr = 5'd1;
		rt_armed = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		load_directed();
		foreach (directed_rows[i])
			offer_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].r);

		wait_idle();
		write_address(5'd31);
		quiet_bus = 1'b1;
		random_traffic(80);

		wait_idle();
		quiet_bus = 1'b0;
		write_address(5'd0);
		// long hold on the result side while a full transmit is in flight
		holds_asked++;
		offer_word(make_cmd(5'd0, 1'b1, 5'd3, 5'd31), 1'b0, '0);
		random_traffic(80);

		wait_idle();
		write_address(5'($urandom_range(2, 30)));
		random_traffic(80);

		wait_idle();
		write_address(5'd1);
		random_traffic(80);

		wait_idle();
		$display("run: %0d words taken, %0d answered, %0d result beats checked, %0d events",
			words_taken, answered_items, results_checked, events_seen);
		$display("run: %0d terminal addresses written, one long result hold", addresses_used);
		if (fail_count == 0)
			$display("PASS bus_remote_terminal_responder_top");
		else
			$display("FAIL bus_remote_terminal_responder_top");
		$finish;
	end

endmodule
